### src/ced_pkg.sv
// Shared types, constants and helper functions for the escape sequence decoder.
// Used by ced_decode, ced_out_fifo and c_escape_sequence_decoder_core; depends on nothing.
package ced_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_OCT    = 3'd2,
        MODE_XPEND  = 3'd3,
        MODE_HEX    = 3'd4
    } t_mode;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X   = 8'h58;

    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;

    // One result item as it sits in the output queue.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_item;
        logic        string_end;
        logic [15:0] byte_count;
    } t_result;

    // Up to two results written into the queue in one cycle.
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Simple escape letters: returns {found, code}.
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] res;
        begin
            case (c)
                8'h61:   res = {1'b1, 8'h07};   // a
                8'h62:   res = {1'b1, 8'h08};   // b
                8'h6E:   res = {1'b1, 8'h0A};   // n
                8'h72:   res = {1'b1, 8'h0D};   // r
                8'h74:   res = {1'b1, 8'h09};   // t
                8'h76:   res = {1'b1, 8'h0B};   // v
                8'h3F:   res = {1'b1, 8'h3F};   // ?
                8'h22:   res = {1'b1, 8'h22};   // double quote
                8'h27:   res = {1'b1, 8'h27};   // single quote
                default: res = {1'b0, 8'h00};
            endcase
            return res;
        end
    endfunction

    // Hex digit decode: returns {valid, value}.
    function automatic logic [4:0] hex_map(input logic [7:0] c);
        logic [4:0] res;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                res = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                res = {1'b1, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                res = {1'b1, 4'(c - 8'h37)};
            end else begin
                res = 5'd0;
            end
            return res;
        end
    endfunction

endpackage

### src/ced_decode.sv
// Input register, parser state and per-byte decode for the escape sequence decoder.
// Depends on ced_pkg; feeds up to two result items per cycle into ced_out_fifo.
module ced_decode #(
    parameter int COUNT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    output logic            o_busy,
    output ced_pkg::t_push  o_push
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    ced_pkg::t_mode        r_mode,  n_mode;
    logic [7:0]            r_value, n_value;
    logic                  r_x_upper, n_x_upper;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic [COUNT_BITS-1:0] cnt_a, cnt_b;
    logic                  pre_emit;
    logic [7:0]            pre_byte;
    logic                  pl_emit, pl_term;
    logic [7:0]            pl_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_accept;
        end
        if (i_accept) begin
            r_in_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ced_pkg::MODE_NORMAL;
            r_value   <= 8'd0;
            r_x_upper <= 1'b0;
            r_count   <= '0;
        end else if (r_in_valid) begin
            r_mode    <= n_mode;
            r_value   <= n_value;
            r_x_upper <= n_x_upper;
            r_count   <= n_count;
        end
    end

    function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
        end
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [8:0] esc;
        logic [4:0] hx;
        logic       is_oct;
        logic       do_plain;
        logic       emit0, emit1;
        logic       term0, term1;
        logic [7:0] byte0, byte1;

        c        = r_in_byte;
        esc      = ced_pkg::esc_map(c);
        hx       = ced_pkg::hex_map(c);
        is_oct   = (c >= 8'h30) && (c <= 8'h37);
        n_mode    = r_mode;
        n_value   = r_value;
        n_x_upper = r_x_upper;
        pre_emit = 1'b0;
        pre_byte = r_value;
        do_plain = 1'b0;
        pl_emit  = 1'b0;
        pl_term  = 1'b0;
        pl_byte  = c;

        case (r_mode)
            ced_pkg::MODE_ESC: begin
                n_mode = ced_pkg::MODE_NORMAL;
                if (c == ced_pkg::CHAR_NUL) begin
                    pl_term = 1'b1;
                end else if (c == ced_pkg::CHAR_NEWLINE) begin
                    pl_emit = 1'b0;
                end else if (esc[8]) begin
                    pl_emit = 1'b1;
                    pl_byte = esc[7:0];
                end else if (is_oct) begin
                    n_value = c - ced_pkg::CHAR_ZERO;
                    n_mode  = ced_pkg::MODE_OCT;
                end else if (c == ced_pkg::CHAR_LOWER_X || c == ced_pkg::CHAR_UPPER_X) begin
                    n_x_upper = (c == ced_pkg::CHAR_UPPER_X);
                    n_mode    = ced_pkg::MODE_XPEND;
                end else begin
                    pl_emit = 1'b1;
                end
            end
            ced_pkg::MODE_OCT: begin
                if (is_oct) begin
                    n_value = {r_value[4:0], c[2:0]};
                end else begin
                    pre_emit = 1'b1;
                    do_plain = 1'b1;
                end
            end
            ced_pkg::MODE_XPEND: begin
                if (hx[4]) begin
                    n_value = {4'd0, hx[3:0]};
                    n_mode  = ced_pkg::MODE_HEX;
                end else begin
                    pre_emit = 1'b1;
                    pre_byte = r_x_upper ? ced_pkg::CHAR_UPPER_X : ced_pkg::CHAR_LOWER_X;
                    do_plain = 1'b1;
                end
            end
            ced_pkg::MODE_HEX: begin
                if (hx[4]) begin
                    n_value = {r_value[3:0], hx[3:0]};
                end else begin
                    pre_emit = 1'b1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            n_mode = ced_pkg::MODE_NORMAL;
            if (c == ced_pkg::CHAR_NUL) begin
                pl_term = 1'b1;
            end else if (c == ced_pkg::CHAR_BACKSLASH) begin
                n_mode = ced_pkg::MODE_ESC;
            end else begin
                pl_emit = 1'b1;
            end
        end

        // Slot 0 takes a pending number or x byte if any, otherwise the plain result.
        if (pre_emit) begin
            emit0 = 1'b1;
            term0 = 1'b0;
            byte0 = pre_byte;
            emit1 = pl_emit || pl_term;
            term1 = pl_term;
            byte1 = pl_term ? ced_pkg::CHAR_NUL : pl_byte;
        end else begin
            emit0 = pl_emit || pl_term;
            term0 = pl_term;
            byte0 = pl_term ? ced_pkg::CHAR_NUL : pl_byte;
            emit1 = 1'b0;
            term1 = 1'b0;
            byte1 = 8'd0;
        end

        cnt_a = (emit0 && !(&r_count)) ? r_count + 1'b1 : r_count;
        cnt_b = (emit1 && !(&cnt_a))   ? cnt_a + 1'b1   : cnt_a;
        n_count = cnt_b;

        if (pl_term) begin
            n_mode    = ced_pkg::MODE_NORMAL;
            n_value   = 8'd0;
            n_x_upper = 1'b0;
            n_count   = '0;
        end

        o_push.num = r_in_valid ? (2'(emit0) + 2'(emit1)) : 2'd0;
        o_push.r0.out_byte     = byte0;
        o_push.r0.last_of_item = !emit1;
        o_push.r0.string_end   = term0;
        o_push.r0.byte_count   = term0 ? sat16(cnt_a) : 16'd0;
        o_push.r1.out_byte     = byte1;
        o_push.r1.last_of_item = 1'b1;
        o_push.r1.string_end   = term1;
        o_push.r1.byte_count   = term1 ? sat16(cnt_b) : 16'd0;
    end

    assign o_busy = r_in_valid;

endmodule

### src/ced_out_fifo.sv
// Result queue of the escape sequence decoder: takes up to two items per cycle,
// hands out one per cycle on the stream side when popped. Depends on ced_pkg.
module ced_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ced_pkg::t_push                i_push,
    input  logic                          i_pop,
    output logic                          o_valid,
    output ced_pkg::t_result              o_head,
    output logic [ced_pkg::FIFO_AW:0]     o_count
);

    ced_pkg::t_result                r_mem [ced_pkg::FIFO_DEPTH];
    logic [ced_pkg::FIFO_AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [ced_pkg::FIFO_AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [ced_pkg::FIFO_AW:0]       r_count,  n_count;
    logic [ced_pkg::FIFO_AW-1:0]     wr_ptr_1;

    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + ced_pkg::FIFO_AW'(i_push.num);
        n_rd_ptr = r_rd_ptr + ced_pkg::FIFO_AW'(i_pop);
        n_count  = r_count + (ced_pkg::FIFO_AW + 1)'(i_push.num)
                           - (ced_pkg::FIFO_AW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.r1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### src/c_escape_sequence_decoder_core.sv
// Path: the results of an accepted byte reach the master side through the input register
// and then the result queue.
// Throughput: one input item per cycle while the result queue keeps room for the
// item in the input register plus one more, each item giving up to two results; the output
// side moves one result per cycle while m_axis_tready is high, setting the sustained rate.
// Reset: synchronous active-low i_rst_n clears the parser state, count and queue.
module c_escape_sequence_decoder_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] byte_count
    output logic        m_axis_tlast,   // last_of_item
    output logic        m_axis_tuser    // string_end
);

    logic                        accept;
    logic                        busy;
    logic                        pop;
    ced_pkg::t_push              push;
    ced_pkg::t_result            head;
    logic [ced_pkg::FIFO_AW:0]   fifo_count;
    logic [ced_pkg::FIFO_AW+1:0] reserved;

    // Room must remain for the item in the input register and the new one, two results each.
    assign reserved      = (ced_pkg::FIFO_AW + 2)'(fifo_count)
                         + (busy ? (ced_pkg::FIFO_AW + 2)'(2) : '0)
                         + (ced_pkg::FIFO_AW + 2)'(2);
    assign s_axis_tready = (reserved <= (ced_pkg::FIFO_AW + 2)'(ced_pkg::FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    ced_decode #(
        .COUNT_BITS(COUNT_BITS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_busy   (busy),
        .o_push   (push)
    );

    ced_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {head.byte_count, head.out_byte};
    assign m_axis_tlast = head.last_of_item;
    assign m_axis_tuser = head.string_end;

endmodule
